FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/mhs_pkg.sv
// constants and value conversion functions for the min-heap sort engine
// depends on nothing; used by the channel interfaces and the top level
package mhs_pkg;

   localparam int MAX_ITEMS  = 32;
   localparam int DATA_WIDTH = 32;
   // fixed width of the value fields on both channels
   localparam int VALUE_W    = 32;
   localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [VALUE_W-1:0]    value_type;
   typedef logic [ADDR_W-1:0]            addr_type;
   typedef logic [CNT_W-1:0]             count_type;

   // input word value to stored element: sign extend, then keep DATA_WIDTH bits
   function automatic data_type to_data(input value_type v);
      logic signed [63:0] ext;
      ext = 64'(v);
      return ext[DATA_WIDTH-1:0];
   endfunction

   // stored element to output word value: sign extend, then keep the low bits
   function automatic value_type to_value(input data_type d);
      logic signed [63:0] ext;
      ext = 64'(d);
      return ext[VALUE_W-1:0];
   endfunction

   // signed order of stored elements
   function automatic logic less_than(input data_type a, input data_type b);
      return a < b;
   endfunction

endpackage

FILE: hdl/mhs_if.sv
// valid/ready channel interfaces for the load words and the sorted words
// depends on mhs_pkg
interface mhs_req_if;
   logic                valid;
   logic                ready;
   mhs_pkg::value_type  value;
   logic                last;

   modport source (output valid, value, last, input ready);
   modport sink   (input valid, value, last, output ready);
endinterface

interface mhs_rsp_if;
   logic                valid;
   logic                ready;
   mhs_pkg::value_type  sorted_value;
   logic                final_res;
   logic                overflowed;

   modport source (output valid, sorted_value, final_res, overflowed, input ready);
   modport sink   (input valid, sorted_value, final_res, overflowed, output ready);
endinterface

FILE: hdl/min_heap_sort_engine.sv
// Min-heap sort engine. Load words go into a MAX_ITEMS-entry element memory, one per cycle,
// until a word marked last; words past capacity are dropped and flag overflowed on every
// result of that run. The block then stops taking load words, builds a min-heap in the
// memory and runs heapsort, and streams the elements out in descending order. Everything
// sits in one synchronous memory with two read ports and one write port, and both reads are
// registered. A sift-down moves one heap level per cycle (both children read together, the
// moving element held in a register) and ends with a compare that writes the held element
// into place. A build sift starts in ST_SIFT_START and ST_SIFT_LOAD, and each root swap
// passes ST_SWAP_RD and ST_SWAP_WR. Readout reads the first element in ST_OUT_RD, then each
// result word is captured in ST_OUT_CAP and held in ST_OUT_HOLD until the sink takes it.
// depends on mhs_pkg and the interfaces in mhs_if
module min_heap_sort_engine (
   input  logic       clock,
   input  logic       reset,
   mhs_req_if.sink    req_if,
   mhs_rsp_if.source  rsp_if
);

   localparam logic [3:0] ST_LOAD       = 4'd0;
   localparam logic [3:0] ST_SIFT_START = 4'd1;
   localparam logic [3:0] ST_SIFT_LOAD  = 4'd2;
   localparam logic [3:0] ST_SIFT_CMP   = 4'd3;
   localparam logic [3:0] ST_SWAP_RD    = 4'd4;
   localparam logic [3:0] ST_SWAP_WR    = 4'd5;
   localparam logic [3:0] ST_OUT_RD     = 4'd6;
   localparam logic [3:0] ST_OUT_CAP    = 4'd7;
   localparam logic [3:0] ST_OUT_HOLD   = 4'd8;

   localparam int KID_W = mhs_pkg::ADDR_W + 2;

   // element memory
   mhs_pkg::data_type mem [mhs_pkg::MAX_ITEMS];
   mhs_pkg::data_type rd_a_ff;
   mhs_pkg::data_type rd_b_ff;
   mhs_pkg::addr_type rd_a_addr;
   mhs_pkg::addr_type rd_b_addr;
   logic              wr_en;
   mhs_pkg::addr_type wr_addr;
   mhs_pkg::data_type wr_data;

   // control state
   logic [3:0]          state_ff,  state_in;
   mhs_pkg::count_type  count_ff,  count_in;
   logic                ovf_ff,    ovf_in;
   mhs_pkg::count_type  n_ff,      n_in;
   mhs_pkg::count_type  size_ff,   size_in;
   mhs_pkg::addr_type   node_ff,   node_in;
   mhs_pkg::addr_type   i_ff,      i_in;
   mhs_pkg::addr_type   j_ff,      j_in;
   mhs_pkg::addr_type   k_ff,      k_in;
   logic                phase_ff,  phase_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   mhs_pkg::data_type   node_val_ff, node_val_in;
   mhs_pkg::value_type  rsp_value_ff, rsp_value_in;
   logic                rsp_final_ff, rsp_final_in;
   logic                rsp_ovf_ff,   rsp_ovf_in;

   // sift compare
   logic [KID_W-1:0]    left_w;
   logic [KID_W-1:0]    right_w;
   logic [KID_W-1:0]    size_w;
   logic                move;
   mhs_pkg::addr_type   pick;
   mhs_pkg::data_type   best;
   logic                req_take;
   logic                rsp_take;

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_if.valid && rsp_if.ready;

   assign req_if.ready        = (state_ff == ST_LOAD);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sorted_value = rsp_value_ff;
   assign rsp_if.final_res    = rsp_final_ff;
   assign rsp_if.overflowed   = rsp_ovf_ff;

   // pick the smallest of node and its children inside the heap
   always_comb begin
      left_w = {1'b0, node_ff, 1'b1};
      right_w = left_w + KID_W'(1);
      size_w = KID_W'(size_ff);
      best = node_val_ff;
      move = 1'b0;
      pick = node_ff;
      if ((left_w < size_w) && mhs_pkg::less_than(rd_a_ff, best)) begin
         best = rd_a_ff;
         move = 1'b1;
         pick = left_w[mhs_pkg::ADDR_W-1:0];
      end
      if ((right_w < size_w) && mhs_pkg::less_than(rd_b_ff, best)) begin
         best = rd_b_ff;
         move = 1'b1;
         pick = right_w[mhs_pkg::ADDR_W-1:0];
      end
   end

   // sequencer: load, heap build, extraction, readout
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      node_val_in  = node_val_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[mhs_pkg::ADDR_W-1:0];
      wr_data      = mhs_pkg::to_data(req_if.value);
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < mhs_pkg::CNT_W'(mhs_pkg::MAX_ITEMS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + mhs_pkg::CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_if.last) begin
                  n_in     = count_in;
                  size_in  = count_in;
                  k_in     = '0;
                  phase_in = 1'b0;
                  i_in     = mhs_pkg::ADDR_W'((count_in >> 1) - mhs_pkg::CNT_W'(1));
                  node_in  = mhs_pkg::ADDR_W'((count_in >> 1) - mhs_pkg::CNT_W'(1));
                  if (count_in == mhs_pkg::CNT_W'(1)) begin
                     state_in = ST_OUT_RD;
                  end else begin
                     state_in = ST_SIFT_START;
                  end
               end
            end
         end
         ST_SIFT_START: begin
            rd_a_addr = node_ff;
            state_in  = ST_SIFT_LOAD;
         end
         ST_SIFT_LOAD: begin
            // element to sift, and the reads of its children
            node_val_in = rd_a_ff;
            rd_a_addr   = mhs_pkg::ADDR_W'({node_ff, 1'b1});
            rd_b_addr   = mhs_pkg::ADDR_W'({node_ff, 1'b1} + (mhs_pkg::ADDR_W + 1)'(1));
            state_in    = ST_SIFT_CMP;
         end
         ST_SIFT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            if (move) begin
               // child moves up, held element goes one level down
               wr_data   = best;
               node_in   = pick;
               rd_a_addr = mhs_pkg::ADDR_W'({pick, 1'b1});
               rd_b_addr = mhs_pkg::ADDR_W'({pick, 1'b1} + (mhs_pkg::ADDR_W + 1)'(1));
            end else begin
               wr_data = node_val_ff;
               if (!phase_ff) begin
                  if (i_ff == '0) begin
                     phase_in = 1'b1;
                     j_in     = mhs_pkg::ADDR_W'(n_ff - mhs_pkg::CNT_W'(1));
                     state_in = ST_SWAP_RD;
                  end else begin
                     i_in     = i_ff - mhs_pkg::ADDR_W'(1);
                     node_in  = i_ff - mhs_pkg::ADDR_W'(1);
                     state_in = ST_SIFT_START;
                  end
               end else begin
                  if (j_ff == mhs_pkg::ADDR_W'(1)) begin
                     state_in = ST_OUT_RD;
                  end else begin
                     j_in     = j_ff - mhs_pkg::ADDR_W'(1);
                     state_in = ST_SWAP_RD;
                  end
               end
            end
         end
         ST_SWAP_RD: begin
            rd_a_addr = '0;
            rd_b_addr = j_ff;
            state_in  = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            // root to the end of the heap, end element sifts from the root
            wr_en       = 1'b1;
            wr_addr     = j_ff;
            wr_data     = rd_a_ff;
            node_val_in = rd_b_ff;
            node_in     = '0;
            size_in     = mhs_pkg::CNT_W'(j_ff);
            rd_a_addr   = mhs_pkg::ADDR_W'(1);
            rd_b_addr   = mhs_pkg::ADDR_W'(2);
            state_in    = ST_SIFT_CMP;
         end
         ST_OUT_RD: begin
            rd_a_addr = k_ff;
            state_in  = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = mhs_pkg::to_value(rd_a_ff);
            rsp_final_in = (mhs_pkg::CNT_W'(k_ff) + mhs_pkg::CNT_W'(1)) == n_ff;
            rsp_ovf_in   = ovf_ff;
            state_in     = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in      = k_ff + mhs_pkg::ADDR_W'(1);
                  rd_a_addr = k_ff + mhs_pkg::ADDR_W'(1);
                  state_in  = ST_OUT_CAP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         size_ff      <= '0;
         node_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         size_ff      <= size_in;
         node_ff      <= node_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_val_ff  <= node_val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

FILE: hdl/mhs_checker.sv
// port-level checks for the min-heap sort engine, bound to the top level
// depends on mhs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mhs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mhs_pkg::value_type rsp_sorted_value,
   input logic               rsp_final_res
);

   // no load words taken while a sorted word is on offer
   `ASSERT_SAME(a_no_load_during_out, clock, reset, rsp_valid, !req_ready)

   // a last word closes the load phase
   `ASSERT_NEXT(a_last_stops_load, clock, reset, req_valid && req_ready && req_last, !req_ready)

   // the final sorted word reopens loading
   `ASSERT_NEXT(a_final_reopens, clock, reset, rsp_valid && rsp_ready && rsp_final_res, req_ready)

   // stalled sorted word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sorted_value))

endmodule

bind min_heap_sort_engine mhs_checker u_mhs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_last         (req_if.last),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sorted_value (rsp_if.sorted_value),
   .rsp_final_res    (rsp_if.final_res)
);

FILE: tb/min_heap_sort_engine_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the min-heap sort engine: loads runs of words, predicts
// the descending result stream and checks every sorted word; depends on mhs_pkg and mhs_if
module min_heap_sort_engine_test;

   localparam mhs_pkg::value_type VALUE_MIN = 32'sh8000_0000;
   localparam mhs_pkg::value_type VALUE_MAX = 32'sh7fff_ffff;
   localparam int unsigned RANDOM_WORDS = 240;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 40;

   typedef struct {
      mhs_pkg::value_type sorted_value;
      logic               final_res;
      logic               overflowed;
   } sorted_word_type;

   // predicts each sorted run and checks the result words in order
   class sort_scoreboard;
      mhs_pkg::value_type run_words[$];
      bit                 run_overflow;
      sorted_word_type    words_due[$];
      int unsigned        mismatch_count;

      function void note_load_word(mhs_pkg::value_type value, logic last);
         mhs_pkg::value_type held;
         int                 j;
         sorted_word_type    w;
         // words past capacity are dropped and flag the whole run
         if (run_words.size() < mhs_pkg::MAX_ITEMS) begin
            run_words.push_back(value);
         end else begin
            run_overflow = 1'b1;
         end
         if (!last) return;
         // descending order by insertion, equal values need no tie rule
         for (int i = 1; i < run_words.size(); i++) begin
            held = run_words[i];
            j = i;
            while (j > 0 && run_words[j-1] < held) begin
               run_words[j] = run_words[j-1];
               j--;
            end
            run_words[j] = held;
         end
         foreach (run_words[k]) begin
            w.sorted_value = run_words[k];
            w.final_res    = (k == run_words.size() - 1);
            w.overflowed   = run_overflow;
            words_due.push_back(w);
         end
         run_words.delete();
         run_overflow = 1'b0;
      endfunction

      function void check_sorted_word(mhs_pkg::value_type value, logic final_res,
                                      logic overflowed);
         sorted_word_type w;
         if (words_due.size() == 0) begin
            $error("unexpected sorted word %0d", value);
            mismatch_count++;
            return;
         end
         w = words_due.pop_front();
         if (value !== w.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", w.sorted_value, value);
            mismatch_count++;
         end
         if (final_res !== w.final_res) begin
            $error("final_res: expected %0b, got %0b", w.final_res, final_res);
            mismatch_count++;
         end
         if (overflowed !== w.overflowed) begin
            $error("overflowed: expected %0b, got %0b", w.overflowed, overflowed);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int unsigned idle_cycles = 0;
   sort_scoreboard sorter_sb = new();

   mhs_req_if req_bus ();
   mhs_rsp_if rsp_bus ();

   min_heap_sort_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #2 clock = ~clock;

   // accepted words on both channels, plus the count of cycles with no progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sorter_sb.note_load_word(req_bus.value, req_bus.last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sorter_sb.check_sorted_word(rsp_bus.sorted_value, rsp_bus.final_res,
                                        rsp_bus.overflowed);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // watchdog
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // result side backpressure: long ready stretches, short and long stalls
   initial begin
      int unsigned pick;
      int unsigned span;
      forever begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            rsp_bus.ready <= 1'b1;
            span = $urandom_range(1, 40);
         end else if (pick < 8) begin
            rsp_bus.ready <= 1'b0;
            span = $urandom_range(1, 3);
         end else begin
            rsp_bus.ready <= 1'b0;
            span = $urandom_range(10, 40);
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // full range mostly, with duplicates, extremes and values near the extremes
   function automatic mhs_pkg::value_type pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         6: return mhs_pkg::value_type'($signed($urandom_range(0, 8)) - 4);
         7: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         8: return VALUE_MIN + mhs_pkg::value_type'($urandom_range(0, 3));
         9: return VALUE_MAX - mhs_pkg::value_type'($urandom_range(0, 3));
         default: return mhs_pkg::value_type'($urandom);
      endcase
   endfunction

   // mostly short runs, some full ones and some that overrun the store
   function automatic int unsigned pick_run_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 8);
      if (r < 80) return $urandom_range(9, mhs_pkg::MAX_ITEMS - 1);
      if (r < 88) return mhs_pkg::MAX_ITEMS;
      return $urandom_range(mhs_pkg::MAX_ITEMS + 1, mhs_pkg::MAX_ITEMS + 8);
   endfunction

   task automatic send_word(input mhs_pkg::value_type value, input logic last,
                            input int unsigned gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.last  <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // one data set, last flag on its final word
   task automatic send_run(input mhs_pkg::value_type words[$], input bit burst);
      foreach (words[k]) begin
         send_word(words[k], k == words.size() - 1, burst ? 0 : pick_gap());
      end
   endtask

   // hold the load side until every sorted word has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sorter_sb.words_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      mhs_pkg::value_type run_q[$];
      int unsigned        words_sent;
      int unsigned        run_len;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single-word runs at both extremes
      run_q = {VALUE_MAX};
      send_run(run_q, 1'b0);
      run_q = {VALUE_MIN};
      send_run(run_q, 1'b1);
      // extremes and zero crossing in one run
      run_q = {mhs_pkg::value_type'(0), mhs_pkg::value_type'(-1), VALUE_MIN, VALUE_MAX,
               mhs_pkg::value_type'(1)};
      send_run(run_q, 1'b1);
      // equal elements
      run_q = {mhs_pkg::value_type'(7), mhs_pkg::value_type'(7), mhs_pkg::value_type'(-3),
               mhs_pkg::value_type'(7), mhs_pkg::value_type'(-3)};
      send_run(run_q, 1'b0);
      // ascending pair, then an already descending triple
      run_q = {mhs_pkg::value_type'(5), mhs_pkg::value_type'(6)};
      send_run(run_q, 1'b1);
      run_q = {mhs_pkg::value_type'(300), mhs_pkg::value_type'(20),
               mhs_pkg::value_type'(-1)};
      send_run(run_q, 1'b0);
      wait_for_results();

      // random runs
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 4) == 0) wait_for_results();
         run_len = pick_run_len();
         run_q.delete();
         repeat (run_len) run_q.push_back(pick_value());
         send_run(run_q, $urandom_range(0, 2) == 0);
         words_sent += run_len;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sorter_sb.mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: min_heap_sort_engine.f
+incdir+hdl
hdl/mhs_pkg.sv
hdl/mhs_if.sv
hdl/min_heap_sort_engine.sv
hdl/mhs_checker.sv
tb/min_heap_sort_engine_test.sv
